FILE: design/rmq_pkg.sv
// Types and constants shared by the rotation matrix to quaternion pipeline.
// Depends on nothing.
package rmq_pkg;

  localparam int DW = 16;
  localparam int BRW = 2;

  localparam logic [BRW-1:0] BR_TRACE = 2'd0;
  localparam logic [BRW-1:0] BR_X = 2'd1;
  localparam logic [BRW-1:0] BR_Y = 2'd2;
  localparam logic [BRW-1:0] BR_Z = 2'd3;

  localparam logic signed [DW-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [DW-1:0] SAT_MIN = -16'sd32768;

  typedef logic signed [DW-1:0] smp_t;

endpackage

FILE: design/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion, Shepperd's method, fully pipelined.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_r00..r22 | into block
//   out     | out_valid, out_stall, out_q*    | out of block
//
// One transaction is accepted each cycle unless the output stalls; each passes the
// stage-1 registers, the bit-per-stage square root and divider pipelines, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  smp_t       in_r00, in_r01, in_r02,
  input  smp_t       in_r10, in_r11, in_r12,
  input  smp_t       in_r20, in_r21, in_r22,
  output logic       out_valid,
  input  logic       out_stall,
  output smp_t       out_qw, out_qx, out_qy, out_qz,
  output logic [BRW-1:0] out_branch
);

  localparam int SW = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 3;
  localparam int AW = SW + FRAC_BITS;
  localparam int RW = (AW + 1) / 2;
  localparam int LAT = 1 + RW + DW + 1;

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: branch choice, root argument, numerators.
  logic signed [SW-1:0] tr, a_t, a_x, a_y, a_z, a_sel;
  logic [BRW-1:0] br_nxt, br_r;
  logic signed [DW+1:0] d0_nxt, d1_nxt, d2_nxt, d0_r, d1_r, d2_r;
  logic [AW-1:0] arg_nxt, arg_r;
  logic signed [SW-1:0] one;
  logic v1_r;

  always_comb begin
    one = SW'(1) <<< FRAC_BITS;
    tr = SW'(in_r00) + SW'(in_r11) + SW'(in_r22);
    a_t = tr + one;
    a_x = one + SW'(in_r00) - SW'(in_r11) - SW'(in_r22);
    a_y = one + SW'(in_r11) - SW'(in_r00) - SW'(in_r22);
    a_z = one + SW'(in_r22) - SW'(in_r00) - SW'(in_r11);
    if (tr > 0) begin
      br_nxt = BR_TRACE;
      a_sel = a_t;
      d0_nxt = (DW+2)'(in_r21) - (DW+2)'(in_r12);
      d1_nxt = (DW+2)'(in_r02) - (DW+2)'(in_r20);
      d2_nxt = (DW+2)'(in_r10) - (DW+2)'(in_r01);
    end else if (in_r00 > in_r11 && in_r00 > in_r22) begin
      br_nxt = BR_X;
      a_sel = a_x;
      d0_nxt = (DW+2)'(in_r21) - (DW+2)'(in_r12);
      d1_nxt = (DW+2)'(in_r01) + (DW+2)'(in_r10);
      d2_nxt = (DW+2)'(in_r02) + (DW+2)'(in_r20);
    end else if (in_r11 > in_r22) begin
      br_nxt = BR_Y;
      a_sel = a_y;
      d0_nxt = (DW+2)'(in_r02) - (DW+2)'(in_r20);
      d1_nxt = (DW+2)'(in_r01) + (DW+2)'(in_r10);
      d2_nxt = (DW+2)'(in_r12) + (DW+2)'(in_r21);
    end else begin
      br_nxt = BR_Z;
      a_sel = a_z;
      d0_nxt = (DW+2)'(in_r10) - (DW+2)'(in_r01);
      d1_nxt = (DW+2)'(in_r02) + (DW+2)'(in_r20);
      d2_nxt = (DW+2)'(in_r12) + (DW+2)'(in_r21);
    end
    arg_nxt = (a_sel <= 0) ? '0 : (AW'(a_sel) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br_r <= br_nxt;
      d0_r <= d0_nxt;
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      arg_r <= arg_nxt;
    end
  end

  logic [RW-1:0] root;
  rmq_sqrt #(.AW(AW), .RW(RW)) u_sqrt (
    .clk(clk), .en(en), .arg(arg_r), .root(root)
  );

  // Side data delayed to match the root.
  logic signed [DW+1:0] d0_d [RW+1];
  logic signed [DW+1:0] d1_d [RW+1];
  logic signed [DW+1:0] d2_d [RW+1];
  logic [BRW-1:0] br_d [RW+1];
  assign d0_d[0] = d0_r;
  assign d1_d[0] = d1_r;
  assign d2_d[0] = d2_r;
  assign br_d[0] = br_r;
  for (genvar i = 0; i < RW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        d0_d[i+1] <= d0_d[i];
        d1_d[i+1] <= d1_d[i];
        d2_d[i+1] <= d2_d[i];
        br_d[i+1] <= br_d[i];
      end
    end
  end

  smp_t q0, q1, q2;
  rmq_div #(.RW(RW), .FRAC(FRAC_BITS)) u_div0 (
    .clk(clk), .en(en), .num(d0_d[RW]), .root(root), .quo(q0));
  rmq_div #(.RW(RW), .FRAC(FRAC_BITS)) u_div1 (
    .clk(clk), .en(en), .num(d1_d[RW]), .root(root), .quo(q1));
  rmq_div #(.RW(RW), .FRAC(FRAC_BITS)) u_div2 (
    .clk(clk), .en(en), .num(d2_d[RW]), .root(root), .quo(q2));

  logic [RW-1:0] hr_d [DW+2];
  logic [BRW-1:0] bo_d [DW+2];
  assign hr_d[0] = root >> 1;
  assign bo_d[0] = br_d[RW];
  for (genvar i = 0; i < DW + 1; i++) begin : g_dly2
    always_ff @(posedge clk) begin
      if (en) begin
        hr_d[i+1] <= hr_d[i];
        bo_d[i+1] <= bo_d[i];
      end
    end
  end

  logic [LAT-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], v1_r};
    end
  end

  // Output register.
  smp_t h, qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic [BRW-1:0] bo;
  always_comb begin
    bo = bo_d[DW+1];
    h = (hr_d[DW+1] > RW'(32767)) ? SAT_MAX : DW'(hr_d[DW+1]);
    case (bo)
      BR_TRACE: begin qw_nxt = h; qx_nxt = q0; qy_nxt = q1; qz_nxt = q2; end
      BR_X: begin qw_nxt = q0; qx_nxt = h; qy_nxt = q1; qz_nxt = q2; end
      BR_Y: begin qw_nxt = q0; qx_nxt = q1; qy_nxt = h; qz_nxt = q2; end
      default: begin qw_nxt = q0; qx_nxt = q1; qy_nxt = q2; qz_nxt = h; end
    endcase
  end

  assign out_valid = v_r[LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      out_qw <= qw_nxt;
      out_qx <= qx_nxt;
      out_qy <= qy_nxt;
      out_qz <= qz_nxt;
      out_branch <= bo;
    end
  end

endmodule

FILE: design/rmq_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on rmq_pkg only through the import convention of the project.
module rmq_sqrt
  import rmq_pkg::*;
#(
  parameter int AW = 34,
  parameter int RW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] arg,
  output logic [RW-1:0] root
);

  localparam int PW = 2 * RW;

  logic [PW-1:0] rem_r [RW+1];
  logic [RW-1:0] res_r [RW+1];

  assign rem_r[0] = PW'(arg);
  assign res_r[0] = '0;

  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam int B = RW - 1 - s;
    logic [PW-1:0] trial;
    logic [PW-1:0] rem_q;
    logic [RW-1:0] res_q;
    always_comb begin
      trial = (PW'(res_r[s]) << (B + 1)) | (PW'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[s] >= trial) begin
          rem_q <= rem_r[s] - trial;
          res_q <= res_r[s] | (RW'(1) << B);
        end else begin
          rem_q <= rem_r[s];
          res_q <= res_r[s];
        end
      end
    end
    assign rem_r[s+1] = rem_q;
    assign res_r[s+1] = res_q;
  end

  assign root = res_r[RW];

endmodule

FILE: design/rmq_div.sv
// Pipelined restoring divider giving d * 2^FRAC / (2 * root), truncated and saturated.
// Depends on rmq_pkg for the sample type and saturation limits.
module rmq_div
  import rmq_pkg::*;
#(
  parameter int RW = 17,
  parameter int FRAC = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic signed [DW+1:0] num,
  input  logic [RW-1:0] root,
  output smp_t          quo
);

  localparam int QW = DW + 1;
  localparam int NW = DW + 2 + FRAC;
  localparam int DV = RW + 1;
  localparam int RM = DV + 1;

  logic [NW-1:0] n_r [QW+1];
  logic [RM-1:0] rm_r [QW+1];
  logic [QW-1:0] q_r [QW+1];
  logic [DV-1:0] dv_r [QW+1];
  logic          ng_r [QW+1];
  logic          zr_r [QW+1];
  logic          nz_r [QW+1];
  logic          ov_r [QW+1];

  logic [DW+1:0] mag;
  logic [NW-1:0] mag_s;
  logic [DV-1:0] den;

  always_comb begin
    mag = num[DW+1] ? (DW+2)'(-num) : num;
    mag_s = NW'(mag) << FRAC;
    den = {root, 1'b0};
  end

  // The bits above the quotient width form the starting remainder; when they
  // reach the divisor the quotient cannot fit and is flagged as overflow.
  assign n_r[0] = mag_s;
  assign rm_r[0] = RM'(mag_s >> QW);
  assign q_r[0] = '0;
  assign dv_r[0] = den;
  assign ng_r[0] = num[DW+1];
  assign zr_r[0] = (root == '0);
  assign nz_r[0] = (num != '0);
  assign ov_r[0] = (den != '0) && ((mag_s >> QW) >= NW'(den));

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int B = QW - 1 - s;
    logic [RM-1:0] cand;
    logic [NW-1:0] n_q;
    logic [RM-1:0] rm_q;
    logic [QW-1:0] q_q;
    logic [DV-1:0] dv_q;
    logic ng_q, zr_q, nz_q, ov_q;
    always_comb begin
      cand = {rm_r[s][RM-2:0], n_r[s][B]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= n_r[s];
        dv_q <= dv_r[s];
        ng_q <= ng_r[s];
        zr_q <= zr_r[s];
        nz_q <= nz_r[s];
        ov_q <= ov_r[s];
        if (cand >= RM'(dv_r[s])) begin
          rm_q <= cand - RM'(dv_r[s]);
          q_q <= q_r[s] | (QW'(1) << B);
        end else begin
          rm_q <= cand;
          q_q <= q_r[s];
        end
      end
    end
    assign n_r[s+1] = n_q;
    assign rm_r[s+1] = rm_q;
    assign q_r[s+1] = q_q;
    assign dv_r[s+1] = dv_q;
    assign ng_r[s+1] = ng_q;
    assign zr_r[s+1] = zr_q;
    assign nz_r[s+1] = nz_q;
    assign ov_r[s+1] = ov_q;
  end

  logic [QW-1:0] qf;
  always_comb begin
    qf = q_r[QW];
    if (ov_r[QW] || qf > QW'(32768)) begin
      qf = QW'(32768);
    end
    if (zr_r[QW]) begin
      quo = !nz_r[QW] ? '0 : (ng_r[QW] ? SAT_MIN : SAT_MAX);
    end else if (ng_r[QW]) begin
      quo = DW'(-qf);
    end else if (qf > QW'(32767)) begin
      quo = SAT_MAX;
    end else begin
      quo = DW'(qf);
    end
  end

endmodule
